[hdl/bmpd_pkg.sv]
// shared types and constants of the bmp pixel stream decoder
package bmpd_pkg;

   localparam int HEADER_BYTES = 54;

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4D;

   localparam int POS_SIG_B       = 0;
   localparam int POS_SIG_M       = 1;
   localparam int POS_DATA_OFFSET = 10;
   localparam int POS_WIDTH       = 18;
   localparam int POS_HEIGHT      = 22;
   localparam int POS_DEPTH       = 28;

   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_32 = 16'd32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      KIND_PIXEL      = 3'd0,
      KIND_HEADER     = 3'd1,
      KIND_BAD_SIG    = 3'd2,
      KIND_BAD_FORMAT = 3'd3,
      KIND_BAD_LIMIT  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] pixel_argb;
      logic [23:0] pixel_index;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        frame_last;
   } rsp_type;

   // raw header fields as gathered from the byte stream
   typedef struct packed {
      logic        sig_bad;
      logic [31:0] data_offset;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] bit_depth;
   } hdr_fields_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] abs_height;
      logic        top_down;
   } hdr_check_type;

endpackage

[hdl/bmpd_hdr_check.sv]
// header validation: signature, size, depth, limits and offset
module bmpd_hdr_check
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  hdr_fields_type hdr,
   output hdr_check_type  chk
);

   logic        neg_height;
   logic [31:0] abs_height;

   assign neg_height = hdr.height[31];
   assign abs_height = neg_height ? (32'd0 - hdr.height) : hdr.height;

   always_comb begin
      chk.abs_height = abs_height;
      chk.top_down   = neg_height;
      if (hdr.sig_bad) begin
         chk.kind = KIND_BAD_SIG;
      end else if (hdr.width[31] || (hdr.width == 32'd0) || (hdr.height == 32'd0) ||
                   ((hdr.bit_depth != DEPTH_24) && (hdr.bit_depth != DEPTH_32))) begin
         chk.kind = KIND_BAD_FORMAT;
      end else if ((hdr.width > 32'(MAX_WIDTH)) || (abs_height > 32'(MAX_HEIGHT)) ||
                   (hdr.data_offset < 32'(HEADER_BYTES))) begin
         chk.kind = KIND_BAD_LIMIT;
      end else begin
         chk.kind = KIND_HEADER;
      end
   end

endmodule

[hdl/bmp_pixel_stream_decoder.sv]
// top level of the bmp pixel stream decoder: byte parser and result register
//
//   channel | ports                                  | transfer
//   --------+----------------------------------------+------------------------------
//   request | req_valid, req_stall, req_payload      | one file byte, frame_start flag
//   result  | rsp_valid, rsp_stall, rsp_payload      | one pixel, header or error
//
// the parser state and the result register update at the edge the byte is taken,
// so a byte can follow every cycle while req_stall is low
// a byte yields at most one result, which sits in the result register until taken
// req_stall is raised only while a held result is itself stalled
// synchronous reset puts the parser in the header phase at byte zero
module bmp_pixel_stream_decoder
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // counter widths follow the size limits
   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD,
      PH_DONE
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [31:0]    pos_ff, pos_in;
   hdr_fields_type hdr_ff, hdr_in;
   hdr_check_type  chk;
   logic [COL_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic           top_down_ff, top_down_in;
   logic [23:0]    pix_bytes_ff, pix_bytes_in;
   logic [1:0]     bip_ff, bip_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]     pad_ff, pad_in;
   logic [23:0]    row_base_ff, row_base_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           req_accept;
   logic [23:0]    first_row_base;
   logic [47:0]    first_row_prod;

   // result register is free or being emptied this cycle
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   bmpd_hdr_check #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_hdr_check (
      .hdr (hdr_ff),
      .chk (chk)
   );

   // bottom-up files start writing at the last image row
   assign first_row_prod = (chk.abs_height[23:0] - 24'd1) * hdr_ff.width[23:0];
   assign first_row_base = chk.top_down ? 24'd0 : first_row_prod[23:0];

   always_comb begin
      phase_type   phase_cur;
      logic [31:0] pos_cur;
      logic [31:0] pos_next;
      logic [7:0]  b;
      logic [1:0]  lane;
      logic [23:0] bytes_cur;
      logic [7:0]  alpha;
      logic        emit;
      logic [COL_W-1:0] col_next;
      logic [ROW_W-1:0] row_next;

      phase_in     = phase_ff;
      pos_in       = pos_ff;
      hdr_in       = hdr_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      top_down_in  = top_down_ff;
      pix_bytes_in = pix_bytes_ff;
      bip_in       = bip_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pad_in       = pad_ff;
      row_base_in  = row_base_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      b         = req_payload.data_byte;
      phase_cur = req_payload.frame_start ? PH_HEADER : phase_ff;
      pos_cur   = req_payload.frame_start ? 32'd0 : pos_ff;
      pos_next  = pos_cur + 32'd1;
      lane      = 2'd0;
      bytes_cur = pix_bytes_ff;
      alpha     = ALPHA_OPAQUE;
      emit      = 1'b0;
      col_next  = col_ff + COL_W'(1);
      row_next  = row_ff + ROW_W'(1);

      if (req_accept) begin
         case (phase_cur)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               pos_in   = pos_next;
               // little-endian field capture by byte position
               if (pos_cur == 32'(POS_SIG_B)) begin
                  hdr_in.sig_bad = (b != SIG_B);
               end
               if (pos_cur == 32'(POS_SIG_M)) begin
                  hdr_in.sig_bad = hdr_ff.sig_bad || (b != SIG_M);
               end
               if ((pos_cur >= 32'(POS_DATA_OFFSET)) && (pos_cur <= 32'(POS_DATA_OFFSET + 3))) begin
                  lane = 2'(pos_cur - 32'(POS_DATA_OFFSET));
                  hdr_in.data_offset[{lane, 3'b000} +: 8] = b;
               end
               if ((pos_cur >= 32'(POS_WIDTH)) && (pos_cur <= 32'(POS_WIDTH + 3))) begin
                  lane = 2'(pos_cur - 32'(POS_WIDTH));
                  hdr_in.width[{lane, 3'b000} +: 8] = b;
               end
               if ((pos_cur >= 32'(POS_HEIGHT)) && (pos_cur <= 32'(POS_HEIGHT + 3))) begin
                  lane = 2'(pos_cur - 32'(POS_HEIGHT));
                  hdr_in.height[{lane, 3'b000} +: 8] = b;
               end
               if ((pos_cur >= 32'(POS_DEPTH)) && (pos_cur <= 32'(POS_DEPTH + 1))) begin
                  lane = 2'(pos_cur - 32'(POS_DEPTH));
                  hdr_in.bit_depth[{lane[0], 3'b000} +: 8] = b;
               end
               // last header byte: fields are all in, give header or error
               if (pos_cur == 32'(HEADER_BYTES - 1)) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in              = '0;
                  rsp_in.result_kind  = chk.kind;
                  if (chk.kind != KIND_HEADER) begin
                     phase_in = PH_DONE;
                  end else begin
                     rsp_in.image_width  = hdr_ff.width[12:0];
                     rsp_in.image_height = chk.abs_height[12:0];
                     width_in     = COL_W'(hdr_ff.width);
                     height_in    = ROW_W'(chk.abs_height);
                     top_down_in  = chk.top_down;
                     row_base_in  = first_row_base;
                     col_in       = '0;
                     row_in       = '0;
                     bip_in       = 2'd0;
                     pix_bytes_in = 24'd0;
                     phase_in = (hdr_ff.data_offset > 32'(HEADER_BYTES)) ? PH_SKIP : PH_PIXEL;
                  end
               end
            end
            PH_SKIP: begin
               pos_in = pos_next;
               if (pos_next >= hdr_ff.data_offset) begin
                  phase_in = PH_PIXEL;
               end
            end
            PH_PIXEL: begin
               if (bip_ff != 2'd3) begin
                  case (bip_ff)
                     2'd0:    bytes_cur[7:0]   = b;
                     2'd1:    bytes_cur[15:8]  = b;
                     default: bytes_cur[23:16] = b;
                  endcase
                  pix_bytes_in = bytes_cur;
                  bip_in       = bip_ff + 2'd1;
                  emit         = (bip_ff == 2'd2) && (hdr_ff.bit_depth != DEPTH_32);
               end else begin
                  // fourth byte of a 32-bit pixel carries alpha
                  alpha = b;
                  emit  = 1'b1;
               end
               if (emit) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.result_kind = KIND_PIXEL;
                  rsp_in.pixel_argb  = {alpha, bytes_cur};
                  rsp_in.pixel_index = row_base_ff + 24'(col_ff);
                  bip_in       = 2'd0;
                  pix_bytes_in = 24'd0;
                  col_in       = col_next;
                  if (col_next >= width_ff) begin
                     col_in = '0;
                     row_in = row_next;
                     if (row_next >= height_ff) begin
                        rsp_in.frame_last = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        row_base_in = top_down_ff ? (row_base_ff + 24'(width_ff)) :
                                                    (row_base_ff - 24'(width_ff));
                        // 24-bit rows pad by the low width bits
                        pad_in = (hdr_ff.bit_depth == DEPTH_24) ? 2'(width_ff) : 2'd0;
                        if (pad_in != 2'd0) begin
                           phase_in = PH_PAD;
                        end
                     end
                  end
               end
            end
            PH_PAD: begin
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
               end
               if (pad_in == 2'd0) begin
                  phase_in = PH_PIXEL;
               end
            end
            default: begin
               // done: bytes are dropped until the next frame start
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= 32'd0;
         bip_ff       <= 2'd0;
         col_ff       <= '0;
         row_ff       <= '0;
         pad_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         bip_ff       <= bip_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_ff       <= hdr_in;
      width_ff     <= width_in;
      height_ff    <= height_in;
      top_down_ff  <= top_down_in;
      pix_bytes_ff <= pix_bytes_in;
      row_base_ff  <= row_base_in;
      rsp_ff       <= rsp_in;
   end

   // the final pixel closes the frame
   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_valid_in && rsp_in.frame_last) |=> (phase_ff == PH_DONE))
      else $error("frame_last issued without closing the frame");

   // pixel position stays inside the image while pixels are being read
   a_position_in_image: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_PIXEL) || (phase_ff == PH_PAD)) |->
         ((col_ff < width_ff) && (row_ff < height_ff)))
      else $error("pixel position outside the image");

   // only pixels carry the last-pixel flag
   a_last_only_on_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_last) |-> (rsp_ff.result_kind == KIND_PIXEL))
      else $error("frame_last on a non-pixel result");

endmodule
